>>> hdl/tpps_pkg.sv
`timescale 1ns / 1ps
package tpps_pkg;

  // search range and field widths
  localparam int PRESCALER_LIMIT = 65536;
  localparam int TARGET_W        = 64;
  localparam int DIV_W           = $clog2(PRESCALER_LIMIT + 1);
  localparam int PRESC_W         = 16;
  localparam int RELOAD_W        = 32;
  localparam int STATUS_W        = 2;
  localparam int STEP_CNT_W      = $clog2(TARGET_W);

  localparam int IN_DATA_W  = ((TARGET_W + 1 + 7) / 8) * 8;
  localparam int OUT_FLD_W  = STATUS_W + PRESC_W + RELOAD_W;
  localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

  // largest period allowed for each reload width (register value plus one)
  localparam logic [TARGET_W-1:0] RELOAD_SPAN_16 = 64'h0000_0000_0001_0000;
  localparam logic [TARGET_W-1:0] RELOAD_SPAN_32 = 64'h0000_0001_0000_0000;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOFIT = 2'd2
  } status_t;

  // divider control between sequencer and datapath
  typedef struct packed {
    logic init;
    logic step;
  } div_ctrl_t;

  // microcode
  localparam int PC_W = 3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EVAL,
    OP_RESULT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_TARGET_ZERO,
    C_COUNT_NZ,
    C_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] jump;
  } ucode_t;

  localparam logic [PC_W-1:0] PC_ACCEPT = 3'd0;
  localparam logic [PC_W-1:0] PC_CHECK  = 3'd1;
  localparam logic [PC_W-1:0] PC_INIT   = 3'd2;
  localparam logic [PC_W-1:0] PC_STEP   = 3'd3;
  localparam logic [PC_W-1:0] PC_EVAL   = 3'd4;
  localparam logic [PC_W-1:0] PC_RESULT = 3'd5;
  localparam logic [PC_W-1:0] PC_RETURN = 3'd6;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    case (pc)
      PC_ACCEPT: w = '{OP_ACCEPT,   C_NO_INPUT,    PC_ACCEPT};
      PC_CHECK:  w = '{OP_NOP,      C_TARGET_ZERO, PC_RESULT};
      PC_INIT:   w = '{OP_DIV_INIT, C_NEVER,       PC_INIT};
      PC_STEP:   w = '{OP_DIV_STEP, C_COUNT_NZ,    PC_STEP};
      PC_EVAL:   w = '{OP_EVAL,     C_MORE,        PC_INIT};
      PC_RESULT: w = '{OP_RESULT,   C_OUT_BUSY,    PC_RESULT};
      PC_RETURN: w = '{OP_NOP,      C_ALWAYS,      PC_ACCEPT};
      default:   w = '{OP_NOP,      C_ALWAYS,      PC_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/tpps_divider.sv
`timescale 1ns / 1ps
module tpps_divider
  import tpps_pkg::*;
(
  input  logic                clk,
  input  div_ctrl_t           ctrl,
  input  logic [TARGET_W-1:0] dividend,
  input  logic [DIV_W-1:0]    divisor,
  output logic [TARGET_W-1:0] quotient,
  output logic [DIV_W-1:0]    remainder
);

  logic [DIV_W:0] shifted;
  logic [DIV_W:0] diff;
  logic           take;

  // one restoring step: quotient register shifts dividend bits out and result bits in
  assign shifted = {remainder, quotient[TARGET_W-1]};
  assign diff    = shifted - {1'b0, divisor};
  assign take    = (shifted >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (ctrl.step) begin
      quotient  <= {quotient[TARGET_W-2:0], take};
      remainder <= take ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
    end
  end

endmodule

>>> hdl/timer_prescaler_period_search_core.sv
`timescale 1ns / 1ps
// Timer prescaler / period search. Each input item carries a target tick count per overflow
// and a counter width flag; the block returns one result item with a status (ok, zero target,
// no fitting pair), the prescaler register value and the auto-reload register value, both
// the chosen value minus one. Dividers 1 to 65536 are tried in order; the first divider with
// the largest product divider * floor(target / divider) whose period fits the reload register
// wins, and the search ends at once on an exact product. Each candidate takes one divider
// load, the bit-serial division and one compare, and a zero target goes straight to the
// result. The shared restoring divider works out one quotient bit per cycle. Control runs
// from a seven-step microcode table with conditional jumps. A finished result sits in the
// output register while the next item is already accepted.
module timer_prescaler_period_search_core
  import tpps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // target_count[63:0], counter_is_32bit[64], zero pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], prescaler_value[17:2],
                                           // reload_value[49:18], zero pad
);

  // sequencer
  logic [PC_W-1:0]       pc;
  logic [PC_W-1:0]       pc_next;
  ucode_t                uc;
  logic                  jump_taken;

  // datapath registers
  logic [TARGET_W-1:0]   target;
  logic                  wide;
  logic [DIV_W-1:0]      divider;
  logic [STEP_CNT_W-1:0] bit_cnt;
  logic                  found;
  logic [DIV_W-1:0]      best_rem;
  logic [PRESC_W-1:0]    best_presc;
  logic [RELOAD_W-1:0]   best_reload;

  // divider unit
  div_ctrl_t             div_ctrl;
  logic [TARGET_W-1:0]   quotient;
  logic [DIV_W-1:0]      remainder;

  // candidate evaluation
  logic [TARGET_W-1:0]   span;
  logic                  fits;
  logic                  better;
  logic                  exact;
  logic                  out_busy;
  logic                  accept;
  logic [TARGET_W-1:0]   period_m1;
  logic [DIV_W-1:0]      divider_m1;
  status_t               status;

  assign uc       = ucode_rom(pc);
  assign s_tready = (uc.op == OP_ACCEPT);
  assign accept   = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;

  assign div_ctrl.init = (uc.op == OP_DIV_INIT);
  assign div_ctrl.step = (uc.op == OP_DIV_STEP);

  tpps_divider u_div (
    .clk       (clk),
    .ctrl      (div_ctrl),
    .dividend  (target),
    .divisor   (divider),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // period must be nonzero and period - 1 must fit the reload register
  assign span  = wide ? RELOAD_SPAN_32 : RELOAD_SPAN_16;
  assign fits  = (quotient != '0) && (quotient <= span);
  // product = target - remainder, so a smaller remainder means a larger product
  assign better = fits && (!found || (remainder < best_rem));
  assign exact  = fits && (remainder == '0);

  assign period_m1  = quotient - 1'b1;
  assign divider_m1 = divider - 1'b1;

  // jump conditions
  always_comb begin
    case (uc.cond)
      C_NEVER:       jump_taken = 1'b0;
      C_ALWAYS:      jump_taken = 1'b1;
      C_NO_INPUT:    jump_taken = !s_tvalid;
      C_TARGET_ZERO: jump_taken = (target == '0);
      C_COUNT_NZ:    jump_taken = (bit_cnt != '0);
      C_MORE:        jump_taken = !exact && (divider != DIV_W'(PRESCALER_LIMIT));
      C_OUT_BUSY:    jump_taken = out_busy;
      default:       jump_taken = 1'b1;
    endcase
    pc_next = jump_taken ? uc.jump : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_ACCEPT;
    end else begin
      pc <= pc_next;
    end
  end

  // datapath, driven by the current control word
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else begin
      case (uc.op)
        OP_ACCEPT: begin
          if (accept) begin
            target  <= s_tdata[TARGET_W-1:0];
            wide    <= s_tdata[TARGET_W];
            divider <= DIV_W'(1);
            found   <= 1'b0;
          end
        end
        OP_DIV_INIT: begin
          bit_cnt <= STEP_CNT_W'(TARGET_W - 1);
        end
        OP_DIV_STEP: begin
          bit_cnt <= bit_cnt - 1'b1;
        end
        OP_EVAL: begin
          if (better) begin
            found       <= 1'b1;
            best_rem    <= remainder;
            best_presc  <= divider_m1[PRESC_W-1:0];
            best_reload <= period_m1[RELOAD_W-1:0];
          end
          divider <= divider + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // result status
  always_comb begin
    if (target == '0) begin
      status = ST_ZERO;
    end else if (found) begin
      status = ST_OK;
    end else begin
      status = ST_NOFIT;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((uc.op == OP_RESULT) && !out_busy) begin
      m_tvalid <= 1'b1;
      if (status == ST_OK) begin
        m_tdata <= {(OUT_DATA_W - OUT_FLD_W)'(0), best_reload, best_presc, status};
      end else begin
        m_tdata <= {(OUT_DATA_W - STATUS_W)'(0), status};
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

>>> hdl/tpps_checker.sv
`timescale 1ns / 1ps
module tpps_checker
  import tpps_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic [IN_DATA_W-1:0]  s_tdata,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its bits
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // status is a known code and padding is zero
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[STATUS_W-1:0] != 2'd3) &&
                 (m_tdata[OUT_DATA_W-1:OUT_FLD_W] == '0))
    else $error("bad status code or padding");

  // zero target and no fit carry zero register values
  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[STATUS_W-1:0] != ST_OK) |-> (m_tdata[OUT_FLD_W-1:STATUS_W] == '0))
    else $error("failed search with nonzero register values");

endmodule

bind timer_prescaler_period_search_core tpps_checker u_tpps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/timer_setting_checker.sv
`timescale 1ns / 1ps
module timer_setting_checker
  import tpps_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // target_count, counter_is_32bit, zero pad
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // status, prescaler_value, reload_value, zero pad
  output int                    fail_count,
  output int                    pending,
  output int                    checked,
  output int                    ok_count,
  output int                    zero_count,
  output int                    nofit_count
);

  typedef struct {
    status_t           st;
    logic [PRESC_W-1:0]  psc;
    logic [RELOAD_W-1:0] arr;
  } timer_setting_t;

  timer_setting_t expected_settings[$];

  int n_fail  = 0;
  int n_check = 0;
  int n_ok    = 0;
  int n_zero  = 0;
  int n_nofit = 0;
  int n_wait  = 0;

  assign fail_count  = n_fail;
  assign pending     = n_wait;
  assign checked     = n_check;
  assign ok_count    = n_ok;
  assign zero_count  = n_zero;
  assign nofit_count = n_nofit;

  // first divider with the largest divider * period product, stop on exact product
  function automatic timer_setting_t search_timer_setting(input logic [TARGET_W-1:0] tgt,
                                                          input logic wide);
    timer_setting_t      r;
    logic [TARGET_W-1:0] span, best, best_div, best_per, div, per, prod;
    r.st  = ST_OK;
    r.psc = '0;
    r.arr = '0;
    if (tgt == 0) begin
      r.st = ST_ZERO;
      return r;
    end
    // longest period the reload register can hold
    span     = wide ? RELOAD_SPAN_32 : RELOAD_SPAN_16;
    best     = 0;
    best_div = 1;
    best_per = 1;
    for (div = 1; div <= PRESCALER_LIMIT; div++) begin
      if (tgt >= div) begin
        per = tgt / div;
        if (per != 0 && per <= span) begin
          prod = div * per;
          if (prod > best) begin
            best     = prod;
            best_div = div;
            best_per = per;
          end
          if (prod == tgt) break;
        end
      end
    end
    if (best == 0) begin
      r.st = ST_NOFIT;
      return r;
    end
    r.psc = PRESC_W'(best_div - 1);
    r.arr = RELOAD_W'(best_per - 1);
    return r;
  endfunction

  always @(posedge clk) begin
    timer_setting_t      want;
    logic [STATUS_W-1:0] got_st;
    logic [PRESC_W-1:0]  got_psc;
    logic [RELOAD_W-1:0] got_arr;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_settings.push_back(search_timer_setting(s_tdata[TARGET_W-1:0],
                                                         s_tdata[TARGET_W]));
      if (m_tvalid && m_tready) begin
        got_st  = m_tdata[STATUS_W-1:0];
        got_psc = m_tdata[STATUS_W +: PRESC_W];
        got_arr = m_tdata[STATUS_W+PRESC_W +: RELOAD_W];
        if (expected_settings.size() == 0) begin
          $error("result item with no request outstanding");
          n_fail++;
        end else begin
          want = expected_settings.pop_front();
          n_check++;
          if (got_st !== want.st) begin
            $error("status: expected %0d, actual %0d", want.st, got_st);
            n_fail++;
          end
          if (got_psc !== want.psc) begin
            $error("prescaler_value: expected %0d, actual %0d", want.psc, got_psc);
            n_fail++;
          end
          if (got_arr !== want.arr) begin
            $error("reload_value: expected %0d, actual %0d", want.arr, got_arr);
            n_fail++;
          end
          case (want.st)
            ST_OK:    n_ok++;
            ST_ZERO:  n_zero++;
            default:  n_nofit++;
          endcase
        end
      end
      n_wait = expected_settings.size();
    end
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import tpps_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // target_count[63:0], counter_is_32bit[64], zero pad
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // status[1:0], prescaler_value[17:2], reload_value[49:18]

  int fail_count, pending, checked, ok_count, zero_count, nofit_count;

  // phase flags: random_phase and quiet are set by the request side for the result side, held is the result side's own
  bit random_phase = 1'b0;
  bit quiet        = 1'b0;
  bit held         = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  timer_prescaler_period_search_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  timer_setting_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .ok_count    (ok_count),
    .zero_count  (zero_count),
    .nofit_count (nofit_count)
  );

  // offer one request item, optionally after a short idle burst, and wait for acceptance
  task automatic offer_request(input logic [TARGET_W-1:0] tgt, input logic wide,
                               input bit gaps);
    int                   n;
    logic [IN_DATA_W-1:0] word;
    if (gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    word           = '0;
    word[TARGET_W-1:0] = tgt;
    word[TARGET_W] = wide;
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // result side: one long hold-off once the random part starts, else random bursts
  initial begin : result_side
    int n;
    forever begin
      if (random_phase && !held) begin
        // block fills up with a finished result plus one in progress, then stalls its input
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        // mostly short ready runs, now and then a long stretch with no stall
        n = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 8);
        m_tready <= 1'b1;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin : request_side
    int                  k;
    logic                wide;
    logic [TARGET_W-1:0] tgt, per, mult;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // zero target, both widths
    offer_request(64'd0, 1'b0, 1'b1);
    offer_request(64'd0, 1'b1, 1'b1);
    // smallest target, divider one
    offer_request(64'd1, 1'b0, 1'b1);
    offer_request(64'd1, 1'b1, 1'b1);
    // period just below and exactly filling each reload register
    offer_request(64'h0000_0000_0000_FFFF, 1'b0, 1'b1);
    offer_request(64'h0000_0000_0001_0000, 1'b0, 1'b1);
    offer_request(64'h0000_0000_FFFF_FFFF, 1'b1, 1'b1);
    offer_request(64'h0000_0001_0000_0000, 1'b1, 1'b1);
    // period too long for divider one, exact at a small divider
    offer_request(64'h0000_0000_0002_0000, 1'b0, 1'b1);
    offer_request(64'h0000_0000_0003_0000, 1'b0, 1'b1);
    offer_request(64'h0000_0000_0040_0000, 1'b0, 1'b1);
    offer_request(64'h0000_0001_0000_0002, 1'b1, 1'b1);
    offer_request(64'h0000_0002_0000_0000, 1'b1, 1'b1);
    // prime just past the 16-bit span: no exact product, full search, smallest divider wins ties
    offer_request(64'h0000_0000_0001_0001, 1'b0, 1'b1);
    // largest target: nothing fits, full search
    offer_request(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);

    // random part: target = small divider * fitting period so every search stops early
    random_phase = 1'b1;
    for (k = 0; k < 100; k++) begin
      if (k == 80) quiet = 1'b1;
      wide = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 19) == 0) begin
        tgt = '0;
      end else begin
        if ($urandom_range(0, 9) == 0)
          per = wide ? RELOAD_SPAN_32 : RELOAD_SPAN_16;
        else if (wide)
          per = {32'd0, $urandom} + 64'd1;
        else
          per = 64'($urandom_range(1, 65536));
        mult = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(9, 64)) :
                                             64'($urandom_range(1, 8));
        tgt  = per * mult;
      end
      offer_request(tgt, wide, !quiet);
    end
    s_tvalid <= 1'b0;

    // let the last accepted request reach the scoreboard, drain, then wait for any stray result
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d requests: %0d set up, %0d zero targets, %0d with no fitting pair",
             checked, ok_count, zero_count, nofit_count);
    $display("both counter widths, two exhaustive searches and one long output hold-off");
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // watchdog: the time limit leaves room for the two exhaustive searches
  initial begin : watchdog
    #150_000_000;
    $error("run did not complete within the time limit");
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> files.f
hdl/tpps_pkg.sv
hdl/tpps_divider.sv
hdl/timer_prescaler_period_search_core.sv
hdl/tpps_checker.sv
verif/timer_setting_checker.sv
verif/testbench.sv
